[rtl/core/radial_density_histogram_core_macros.svh]
// assertion macros for the radial density histogram core
// used by the port-level checker; no other dependencies
`ifndef RADIAL_DENSITY_HISTOGRAM_CORE_MACROS_SVH
`define RADIAL_DENSITY_HISTOGRAM_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RDH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked on every rising clock edge, reset included
`define RDH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[rtl/core/rdh_pkg.sv]
// shared types, constants and helpers of the radial density histogram core
// no dependencies
`default_nettype none

package rdh_pkg;

   localparam int NUM_BINS   = 64;
   localparam int COORD_BITS = 24;

   localparam int ADDR_BITS   = $clog2(NUM_BINS);
   localparam int CMD_BITS    = 2;
   localparam int IDX_BITS    = 6;
   localparam int COUNT_BITS  = 32;
   localparam int DENS_BITS   = 32;
   localparam int BCNT_BITS   = 7;
   localparam int WIDTH_BITS  = 24;
   localparam int GAIN_BITS   = 32;
   localparam int FRAME_BITS  = 32;

   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int MAG_BITS    = 31;
   localparam int FAR_BITS    = 33;

   localparam int WIDE_BITS   = 64;
   localparam int ROOT_BITS   = 32;
   localparam int REM_BITS    = 66;
   localparam int ITER_STEPS  = 32;
   localparam int STEP_BITS   = $clog2(ITER_STEPS);
   localparam int SHELL_BITS  = 2 * IDX_BITS + 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_FIELD_BITS = 3 * COORD_BITS + IDX_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = IDX_BITS + COUNT_BITS + DENS_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TOTAL_LSB  = IDX_BITS;
   localparam int RSP_DENS_LSB   = IDX_BITS + COUNT_BITS;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] REG_BIN_COUNT = 2'd0;
   localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
   localparam logic [1:0] REG_NORM_GAIN = 2'd2;

   localparam logic [BCNT_BITS-1:0]  BIN_COUNT_RESET = 7'd64;
   localparam logic [WIDTH_BITS-1:0] BIN_WIDTH_RESET = 24'd4096;
   localparam logic [GAIN_BITS-1:0]  NORM_GAIN_RESET = 32'd65536;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_FRAME    = 2'd1,
      CMD_PARTICLE = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type               op;
      logic [MAG_BITS-1:0]   mag_x;
      logic [MAG_BITS-1:0]   mag_y;
      logic [MAG_BITS-1:0]   mag_z;
      logic [IDX_BITS-1:0]   idx;
   } job_type;

   typedef struct packed {
      logic start;
      logic div_mode;
   } iter_ctl_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_ROOT_GO,
      BK_ROOT_WAIT,
      BK_DIV_GO,
      BK_DIV_WAIT,
      BK_BIN_READ,
      BK_BIN_WRITE,
      BK_RD_FETCH,
      BK_RD_MUL_NUM,
      BK_RD_MUL_DEN,
      BK_RD_CHECK,
      BK_RD_WAIT,
      BK_OUT
   } back_state_type;

   // 3i^2 + 3i + 1, relative volume of shell i
   function automatic logic [SHELL_BITS-1:0] shell_of(input logic [IDX_BITS-1:0] idx);
      logic [SHELL_BITS-1:0] i;
      i = SHELL_BITS'(idx);
      return SHELL_BITS'(i * (i + SHELL_BITS'(1)) * SHELL_BITS'(3) + SHELL_BITS'(1));
   endfunction

endpackage

`default_nettype wire

[rtl/core/rdh_queue.sv]
// small request queue between the front and back parts
// depends on rdh_pkg
`default_nettype none

module rdh_queue
   import rdh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    not_empty
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_BITS-1:0]  fill_ff, fill_in;
   logic                   do_pop;

   assign full      = (fill_ff == QFILL_BITS'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + QFILL_BITS'(1);
      end else if (do_pop && !push) begin
         fill_in = fill_ff - QFILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rdh_front.sv]
// front part: accepts requests, holds the frame centre, forms coordinate magnitudes
// depends on rdh_pkg
`default_nettype none

module rdh_front
   import rdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CMD_BITS-1:0]   in_cmd,
   input  logic [COORD_BITS-1:0] in_pos_x,
   input  logic [COORD_BITS-1:0] in_pos_y,
   input  logic [COORD_BITS-1:0] in_pos_z,
   input  logic [IDX_BITS-1:0]   in_read_index,
   input  logic                  queue_full,
   output logic                  push,
   output job_type               push_job
);

   logic [COORD_BITS-1:0] centre_ff [3];
   logic [COORD_BITS-1:0] centre_in [3];
   logic [COORD_BITS-1:0] pos [3];
   logic [DIFF_BITS-1:0]  diff [3];
   logic [DIFF_BITS-1:0]  diff_abs [3];
   logic [FAR_BITS-1:0]   mag_wide [3];
   logic [MAG_BITS-1:0]   mag [3];
   logic                  far;
   logic                  accept;
   cmd_type               op;

   assign pos[0]   = in_pos_x;
   assign pos[1]   = in_pos_y;
   assign pos[2]   = in_pos_z;
   assign op       = cmd_type'(in_cmd);
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      far = 1'b0;
      for (int a = 0; a < 3; a++) begin
         diff[a]     = {pos[a][COORD_BITS-1], pos[a]} -
                       {centre_ff[a][COORD_BITS-1], centre_ff[a]};
         diff_abs[a] = diff[a][DIFF_BITS-1] ? (~diff[a] + DIFF_BITS'(1)) : diff[a];
         mag_wide[a] = FAR_BITS'(diff_abs[a]);
         // magnitude of 2^31 or more lies beyond every bin
         far         = far | (|mag_wide[a][FAR_BITS-1:MAG_BITS]);
         mag[a]      = mag_wide[a][MAG_BITS-1:0];
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         centre_in[a] = (accept && op == CMD_FRAME) ? pos[a] : centre_ff[a];
      end
      push           = accept && !(op == CMD_PARTICLE && far);
      push_job.op    = op;
      push_job.mag_x = mag[0];
      push_job.mag_y = mag[1];
      push_job.mag_z = mag[2];
      push_job.idx   = in_read_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            centre_ff[a] <= '0;
         end
      end else begin
         for (int a = 0; a < 3; a++) begin
            centre_ff[a] <= centre_in[a];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/rdh_iter.sv]
// shared iterative unit: integer square root or long division, one result bit per cycle
// depends on rdh_pkg
`default_nettype none

module rdh_iter
   import rdh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  iter_ctl_type         ctl,
   input  logic [WIDE_BITS-1:0] num,
   input  logic [WIDE_BITS-1:0] den,
   output logic                 done,
   output logic [ROOT_BITS-1:0] result
);

   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [WIDE_BITS-1:0] acc_ff, acc_in;
   logic [WIDE_BITS-1:0] den_ff, den_in;
   logic [ROOT_BITS-1:0] quo_ff, quo_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 mode_ff, mode_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_BITS-1:0]  shifted, trial;
   logic                 ge;

   assign done   = done_ff;
   assign result = quo_ff;

   always_comb begin
      // division brings down one numerator bit, the root two radicand bits
      shifted = mode_ff ? {rem_ff[REM_BITS-2:0], acc_ff[WIDE_BITS-1]} :
                          {rem_ff[REM_BITS-3:0], acc_ff[WIDE_BITS-1 -: 2]};
      trial   = mode_ff ? REM_BITS'(den_ff) : REM_BITS'({quo_ff, 2'b01});
      ge      = (shifted >= trial);

      rem_in  = rem_ff;
      acc_in  = acc_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctl.start) begin
         mode_in = ctl.div_mode;
         den_in  = den;
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         if (ctl.div_mode) begin
            rem_in = REM_BITS'(num[WIDE_BITS-1:ROOT_BITS]);
            acc_in = {num[ROOT_BITS-1:0], {(WIDE_BITS-ROOT_BITS){1'b0}}};
         end else begin
            rem_in = '0;
            acc_in = num;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? (shifted - trial) : shifted;
         acc_in  = mode_ff ? {acc_ff[WIDE_BITS-2:0], 1'b0} : {acc_ff[WIDE_BITS-3:0], 2'b00};
         quo_in  = {quo_ff[ROOT_BITS-2:0], ge};
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(ITER_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         mode_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

[rtl/core/rdh_back.sv]
// back part: bin memory, frame count, shared multiplier and sequencer for each request
// depends on rdh_pkg and rdh_iter
`default_nettype none

module rdh_back
   import rdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  pop,
   input  logic [BCNT_BITS-1:0]  bin_count,
   input  logic [WIDTH_BITS-1:0] bin_width,
   input  logic [GAIN_BITS-1:0]  norm_gain,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [IDX_BITS-1:0]   out_bin_number,
   output logic [COUNT_BITS-1:0] out_bin_total,
   output logic [DENS_BITS-1:0]  out_density
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
   localparam logic [DENS_BITS-1:0]  DENS_MAX  = '1;

   back_state_type          state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [1:0]              step_ff, step_in;
   logic [WIDE_BITS-1:0]    prod_ff, prod_in;
   logic [WIDE_BITS-1:0]    sum_ff, sum_in;
   logic [WIDE_BITS-1:0]    num_ff, num_in;
   logic [ROOT_BITS-1:0]    bin_ff, bin_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [DENS_BITS-1:0]    dens_ff, dens_in;
   logic [FRAME_BITS-1:0]   frame_ff, frame_in;
   logic [NUM_BINS-1:0]     valid_ff, valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic [IDX_BITS-1:0]     out_num_ff, out_num_in;
   logic [COUNT_BITS-1:0]   out_total_ff, out_total_in;
   logic [DENS_BITS-1:0]    out_dens_ff, out_dens_in;

   logic [COUNT_BITS-1:0]   mem [NUM_BINS];
   logic [COUNT_BITS-1:0]   rd_data_ff;
   logic                    rd_valid_ff;
   logic                    rd_en, wr_en;
   logic [ADDR_BITS-1:0]    rd_addr, wr_addr;
   logic [COUNT_BITS-1:0]   wr_data;

   logic [ROOT_BITS-1:0]    mul_a, mul_b;
   logic [ROOT_BITS-1:0]    active, idx_wide;
   logic [COUNT_BITS-1:0]   cur_count;
   logic [WIDE_BITS-1:0]    width_wide;
   logic                    idx_ok;

   iter_ctl_type            iter_ctl;
   logic [WIDE_BITS-1:0]    iter_num, iter_den;
   logic                    iter_done;
   logic [ROOT_BITS-1:0]    iter_result;

   rdh_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .num    (iter_num),
      .den    (iter_den),
      .done   (iter_done),
      .result (iter_result)
   );

   assign out_valid      = out_valid_ff;
   assign out_bin_number = out_num_ff;
   assign out_bin_total  = out_total_ff;
   assign out_density    = out_dens_ff;

   assign active     = (ROOT_BITS'(bin_count) < ROOT_BITS'(NUM_BINS)) ?
                       ROOT_BITS'(bin_count) : ROOT_BITS'(NUM_BINS);
   assign width_wide = (bin_width == '0) ? WIDE_BITS'(1) : WIDE_BITS'(bin_width);
   assign idx_wide   = ROOT_BITS'(job_ff.idx);
   assign idx_ok     = idx_wide < ROOT_BITS'(NUM_BINS);
   assign cur_count  = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      bin_in       = bin_ff;
      count_in     = count_ff;
      dens_in      = dens_ff;
      frame_in     = frame_ff;
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_num_in   = out_num_ff;
      out_total_in = out_total_ff;
      out_dens_in  = out_dens_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = bin_ff[ADDR_BITS-1:0];
      wr_en        = 1'b0;
      wr_addr      = bin_ff[ADDR_BITS-1:0];
      wr_data      = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
      mul_a        = '0;
      mul_b        = '0;
      iter_ctl     = '0;
      iter_num     = num_ff;
      iter_den     = prod_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               pop    = 1'b1;
               job_in = job;
               unique case (job.op)
                  CMD_CLEAR: begin
                     valid_in = '0;
                     frame_in = '0;
                  end
                  CMD_FRAME: begin
                     if (frame_ff != FRAME_MAX) begin
                        frame_in = frame_ff + FRAME_BITS'(1);
                     end
                  end
                  CMD_PARTICLE: begin
                     step_in  = '0;
                     state_in = BK_SQUARE;
                  end
                  CMD_READ: begin
                     state_in = BK_RD_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SQUARE: begin
            // one square per cycle, each summed in the cycle after it is formed
            unique case (step_ff)
               2'd0: mul_a = ROOT_BITS'(job_ff.mag_x);
               2'd1: mul_a = ROOT_BITS'(job_ff.mag_y);
               2'd2: mul_a = ROOT_BITS'(job_ff.mag_z);
               default: mul_a = '0;
            endcase
            mul_b   = mul_a;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd1) begin
               sum_in = prod_ff;
            end else if (step_ff != 2'd0) begin
               sum_in = sum_ff + prod_ff;
            end
            if (step_ff == 2'd3) begin
               state_in = BK_ROOT_GO;
            end
         end
         BK_ROOT_GO: begin
            iter_ctl.start    = 1'b1;
            iter_ctl.div_mode = 1'b0;
            iter_num          = sum_ff;
            state_in          = BK_ROOT_WAIT;
         end
         BK_ROOT_WAIT: begin
            if (iter_done) begin
               bin_in   = iter_result;
               state_in = BK_DIV_GO;
            end
         end
         BK_DIV_GO: begin
            iter_ctl.start    = 1'b1;
            iter_ctl.div_mode = 1'b1;
            iter_num          = WIDE_BITS'(bin_ff);
            iter_den          = width_wide;
            state_in          = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (iter_done) begin
               bin_in   = iter_result;
               state_in = BK_BIN_READ;
            end
         end
         BK_BIN_READ: begin
            if (bin_ff < active) begin
               rd_en    = 1'b1;
               state_in = BK_BIN_WRITE;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_BIN_WRITE: begin
            wr_en             = 1'b1;
            valid_in[wr_addr] = 1'b1;
            state_in          = BK_IDLE;
         end
         BK_RD_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = idx_wide[ADDR_BITS-1:0];
            state_in = BK_RD_MUL_NUM;
         end
         BK_RD_MUL_NUM: begin
            count_in = idx_ok ? cur_count : '0;
            mul_a    = idx_ok ? cur_count : '0;
            mul_b    = norm_gain;
            state_in = BK_RD_MUL_DEN;
         end
         BK_RD_MUL_DEN: begin
            num_in   = prod_ff;
            mul_a    = ROOT_BITS'(shell_of(job_ff.idx));
            mul_b    = frame_ff;
            state_in = BK_RD_CHECK;
         end
         BK_RD_CHECK: begin
            // quotient fits 32 bits exactly when the upper numerator half is below the divisor
            if (!idx_ok || frame_ff == '0) begin
               dens_in  = '0;
               state_in = BK_OUT;
            end else if (WIDE_BITS'(num_ff[WIDE_BITS-1:ROOT_BITS]) >= prod_ff) begin
               dens_in  = DENS_MAX;
               state_in = BK_OUT;
            end else begin
               iter_ctl.start    = 1'b1;
               iter_ctl.div_mode = 1'b1;
               state_in          = BK_RD_WAIT;
            end
         end
         BK_RD_WAIT: begin
            if (iter_done) begin
               dens_in  = iter_result;
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_num_in   = job_ff.idx;
               out_total_in = count_ff;
               out_dens_in  = dens_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         frame_ff     <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      num_ff       <= num_in;
      bin_ff       <= bin_in;
      count_ff     <= count_in;
      dens_ff      <= dens_in;
      out_num_ff   <= out_num_in;
      out_total_ff <= out_total_in;
      out_dens_ff  <= out_dens_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/radial_density_histogram_core.sv]
// top level of the radial density histogram core: register port, front, queue, back
// depends on rdh_pkg, rdh_front, rdh_queue, rdh_back
//
//   port group   direction   carries
//   req_*        in          one command with centre/particle position or bin index
//   rsp_*        out         one bin read result (count and density) per read command
//   csr_*        in/out      bin_count, bin_width, norm_gain registers
//
// clear and frame commands are handled in the idle state of the back part; a bin read
// fetches, multiplies and checks, and may also divide; a particle is squared and summed,
// then the shared square-root/divide unit takes the root and then the division, followed by
// a read-modify-write of the bin that is skipped when its bin is outside the active range
// the front keeps accepting while the two-entry queue has room, and a finished read
// result waits in the output register without blocking the back part until its next one
// synchronous active-high reset clears all bins, the centre and the frame count
`default_nettype none

module radial_density_histogram_core
   import rdh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // pos_x, pos_y, pos_z, read_index, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic [CMD_BITS-1:0]      req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // bin_number, bin_total, density, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [BCNT_BITS-1:0]  bin_count_ff, bin_count_in;
   logic [WIDTH_BITS-1:0] bin_width_ff, bin_width_in;
   logic [GAIN_BITS-1:0]  norm_gain_ff, norm_gain_in;
   logic                  csr_write;
   logic [1:0]            csr_index;

   logic                  q_push, q_pop, q_full, q_not_empty;
   job_type               q_in_job, q_head_job;
   logic [IDX_BITS-1:0]   rsp_bin_number;
   logic [COUNT_BITS-1:0] rsp_bin_total;
   logic [DENS_BITS-1:0]  rsp_density;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      bin_count_in = bin_count_ff;
      bin_width_in = bin_width_ff;
      norm_gain_in = norm_gain_ff;
      csr_prdata   = '0;
      unique case (csr_index)
         REG_BIN_COUNT: begin
            csr_prdata = CSR_DATA_BITS'(bin_count_ff);
            if (csr_write) begin
               bin_count_in = csr_pwdata[BCNT_BITS-1:0];
            end
         end
         REG_BIN_WIDTH: begin
            csr_prdata = CSR_DATA_BITS'(bin_width_ff);
            if (csr_write) begin
               bin_width_in = csr_pwdata[WIDTH_BITS-1:0];
            end
         end
         REG_NORM_GAIN: begin
            csr_prdata = CSR_DATA_BITS'(norm_gain_ff);
            if (csr_write) begin
               norm_gain_in = csr_pwdata[GAIN_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_COUNT_RESET;
         bin_width_ff <= BIN_WIDTH_RESET;
         norm_gain_ff <= NORM_GAIN_RESET;
      end else begin
         bin_count_ff <= bin_count_in;
         bin_width_ff <= bin_width_in;
         norm_gain_ff <= norm_gain_in;
      end
   end

   rdh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_cmd        (req_tuser),
      .in_pos_x      (req_tdata[COORD_BITS-1:0]),
      .in_pos_y      (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .in_pos_z      (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .in_read_index (req_tdata[REQ_FIELD_BITS-1:3*COORD_BITS]),
      .queue_full    (q_full),
      .push          (q_push),
      .push_job      (q_in_job)
   );

   rdh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_in_job),
      .pop       (q_pop),
      .head_job  (q_head_job),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   rdh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q_not_empty),
      .job            (q_head_job),
      .pop            (q_pop),
      .bin_count      (bin_count_ff),
      .bin_width      (bin_width_ff),
      .norm_gain      (norm_gain_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_bin_number (rsp_bin_number),
      .out_bin_total  (rsp_bin_total),
      .out_density    (rsp_density)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_density, rsp_bin_total, rsp_bin_number});

endmodule

`default_nettype wire

[rtl/core/rdh_checker.sv]
// port-level checker for the radial density histogram core, bound to the top level
// depends on rdh_pkg and the core's assertion macro header
`default_nettype none
`include "radial_density_histogram_core_macros.svh"

module rdh_checker
   import rdh_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     csr_psel,
   input logic                     csr_pready
);

   logic [COUNT_BITS-1:0] seen_total;
   logic [DENS_BITS-1:0]  seen_density;

   assign seen_total   = rsp_tdata[RSP_DENS_LSB-1:RSP_TOTAL_LSB];
   assign seen_density = rsp_tdata[RSP_FIELD_BITS-1:RSP_DENS_LSB];

   // an empty bin never reports a density
   `RDH_ASSERT(a_empty_bin_zero_density, clock, reset, rsp_tvalid && seen_total == '0 |-> seen_density == '0, "nonzero density for an empty bin")
   // reset leaves no result pending
   `RDH_ASSERT_ALWAYS(a_reset_drops_result, clock, reset |=> !rsp_tvalid, "result valid right after reset")
   `RDH_ASSERT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `RDH_ASSERT(a_csr_ready, clock, reset, csr_psel |-> csr_pready, "register port not ready")

endmodule

bind radial_density_histogram_core rdh_checker u_checker (.*);

`default_nettype wire
